### src/gpsec_pkg.sv
// shared constants, types and position tables for the grid parity corrector
package gpsec_pkg;

	localparam int WORD_W = 32;
	localparam int SYN_W = 8;
	localparam int STATUS_W = 2;
	localparam int POSITIONS = 24;
	localparam int POS_IDX_W = $clog2(WORD_W);

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [SYN_W-1:0] syn_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [POS_IDX_W-1:0] pos_idx_t;

	localparam status_t STATUS_OK = 2'd0;
	localparam status_t STATUS_CORRECTED = 2'd1;
	localparam status_t STATUS_UNCORRECTABLE = 2'd2;

	// row bit 7-r for rows 0..3, column bit 3-c for columns 0..3
	localparam syn_t POS_SIG [POSITIONS] = '{
		8'h88, 8'h84, 8'h82, 8'h81, 8'h80,
		8'h48, 8'h44, 8'h42, 8'h41, 8'h40,
		8'h28, 8'h24, 8'h22, 8'h21, 8'h20,
		8'h18, 8'h14, 8'h12, 8'h11, 8'h10,
		8'h08, 8'h04, 8'h02, 8'h01
	};

	// word bit holding payload position p
	function automatic pos_idx_t pos_bit(input int p);
		int b;
		if (p < 8) begin
			b = 16 + p;
		end else if (p < 16) begin
			b = p;
		end else begin
			b = p - 16;
		end
		return pos_idx_t'(b);
	endfunction

endpackage

### src/gpsec_rx_if.sv
// input channel: received word with valid/ready handshake
interface gpsec_rx_if;
	logic valid;
	logic ready;
	gpsec_pkg::word_t received_word;

	modport source (output valid, output received_word, input ready);
	modport sink (input valid, input received_word, output ready);
endinterface

### src/gpsec_tx_if.sv
// output channel: corrected word and status with valid/ready handshake
interface gpsec_tx_if;
	logic valid;
	logic ready;
	gpsec_pkg::word_t corrected_word;
	gpsec_pkg::status_t decode_status;

	modport source (output valid, output corrected_word, output decode_status, input ready);
	modport sink (input valid, input corrected_word, input decode_status, output ready);
endinterface

### src/gpsec_decode.sv
// syndrome computation and single position correction for one word
module gpsec_decode (
	input gpsec_pkg::word_t word,
	output gpsec_pkg::word_t corrected_word,
	output gpsec_pkg::status_t decode_status
);

	gpsec_pkg::syn_t syn;
	gpsec_pkg::word_t flip;
	logic [gpsec_pkg::POSITIONS-1:0] hit;

	always_comb begin
		syn = word[gpsec_pkg::WORD_W-1 -: gpsec_pkg::SYN_W];
		for (int p = 0; p < gpsec_pkg::POSITIONS; p++) begin
			if (word[gpsec_pkg::pos_bit(p)]) begin
				syn = syn ^ gpsec_pkg::POS_SIG[p];
			end
		end
	end

	always_comb begin
		flip = '0;
		for (int p = 0; p < gpsec_pkg::POSITIONS; p++) begin
			hit[p] = (syn == gpsec_pkg::POS_SIG[p]);
			flip[gpsec_pkg::pos_bit(p)] = hit[p];
		end
	end

	always_comb begin
		if (syn == '0) begin
			decode_status = gpsec_pkg::STATUS_OK;
			corrected_word = word;
		end else if (hit != '0) begin
			decode_status = gpsec_pkg::STATUS_CORRECTED;
			corrected_word = word ^ flip;
		end else begin
			decode_status = gpsec_pkg::STATUS_UNCORRECTABLE;
			corrected_word = word;
		end
	end

endmodule

### src/grid_parity_single_error_corrector.sv
// top level: input register, decode logic, result register
// an accepted input word reaches tx through the input register and then the result register
// throughput: one word per cycle while tx is ready; the input register refills as the result register drains
// tx backpressure stalls the result register, then the input register, then rx ready
// reset: arst_n asynchronous active low clears both valid flags, payload is not reset
module grid_parity_single_error_corrector (
	input logic clk,
	input logic arst_n,
	gpsec_rx_if.sink rx,
	gpsec_tx_if.source tx
);

	logic valid_s1;
	logic valid_s2;
	logic adv_s1;
	gpsec_pkg::word_t word_s1;
	gpsec_pkg::word_t word_s2;
	gpsec_pkg::status_t status_s2;
	gpsec_pkg::word_t dec_word;
	gpsec_pkg::status_t dec_status;

	assign adv_s1 = valid_s1 && (!valid_s2 || tx.ready);
	assign rx.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			word_s1 <= rx.received_word;
		end
	end

	gpsec_decode u_decode (
		.word(word_s1),
		.corrected_word(dec_word),
		.decode_status(dec_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (tx.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			word_s2 <= dec_word;
			status_s2 <= dec_status;
		end
	end

	assign tx.valid = valid_s2;
	assign tx.corrected_word = word_s2;
	assign tx.decode_status = status_s2;

	// check byte is never modified
	a_check_byte_kept: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> word_s2[31:24] == $past(word_s1[31:24]))
		else $error("check byte changed by decode");

	// only a corrected word differs from its input, and then by exactly one bit
	a_unchanged_word: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> (status_s2 == gpsec_pkg::STATUS_CORRECTED
			|| word_s2 == $past(word_s1)))
		else $error("word altered without correction");

	a_single_flip: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> (status_s2 != gpsec_pkg::STATUS_CORRECTED
			|| $onehot(word_s2 ^ $past(word_s1))))
		else $error("correction did not flip exactly one bit");

endmodule
